// File: rtl/core/grayscale_erode_dilate_filter_macros.svh
// Assertion macros used by the checker file.
`ifndef GRAYSCALE_ERODE_DILATE_FILTER_MACROS_SVH
`define GRAYSCALE_ERODE_DILATE_FILTER_MACROS_SVH

// Next-cycle implication, masked while reset is high.
`define GEDF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define GEDF_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/gedf_pkg.sv
// -----------------------------------------------------------------------------
// gedf_pkg
// Shared widths, register codes, control types and the min/max select.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gedf_pkg;

   localparam int PIX_W      = 8;
   localparam int CNT_W      = 11;
   localparam int RAD_W      = 3;
   localparam int IDX_W      = 22;
   localparam int MAX_HEIGHT = 1024;
   localparam int QDEPTH     = 4;
   localparam int QPTR_W     = 2;
   localparam int QCNT_W     = 3;
   localparam int REG_IDX_W  = 2;
   localparam int ADDR_W     = 4;
   localparam int DATA_W     = 32;

   localparam logic OP_ERODE  = 1'b0;
   localparam logic OP_DILATE = 1'b1;

   localparam logic [REG_IDX_W-1:0] REG_OPERATION = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_RADIUS    = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_WIDTH     = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_HEIGHT    = 2'd3;

   localparam logic [RAD_W-1:0] RADIUS_RESET = 3'd1;
   localparam logic [CNT_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [CNT_W-1:0] HEIGHT_RESET = 11'd480;

   // Effective (clamped) configuration.
   typedef struct packed {
      logic             op;
      logic [RAD_W-1:0] radius;
      logic [CNT_W-1:0] width;
      logic [CNT_W-1:0] height;
   } cfg_type;

   // Per-item control carried from the front to the back.
   typedef struct packed {
      logic shift;
      logic emit;
      logic interior;
      logic last;
   } ctl_type;

   localparam int CTL_W = $bits(ctl_type);

   function automatic logic [PIX_W-1:0] pick(input logic op, input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
      if (op == OP_DILATE) begin
         return (a > b) ? a : b;
      end
      return (a < b) ? a : b;
   endfunction

   function automatic logic [PIX_W-1:0] neutral(input logic op);
      return (op == OP_DILATE) ? '0 : '1;
   endfunction

endpackage

// File: rtl/core/gedf_tree.sv
// -----------------------------------------------------------------------------
// gedf_tree
// Balanced min/max reduction over a fixed number of pixels.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gedf_tree #(
   parameter int N = 15
) (
   input  logic                      op,
   input  logic [N-1:0][gedf_pkg::PIX_W-1:0] vals,
   output logic [gedf_pkg::PIX_W-1:0] result
);
   import gedf_pkg::*;

   localparam int L = (N > 1) ? $clog2(N) : 1;
   localparam int P = 1 << L;

   logic [PIX_W-1:0] lv [L+1][P];

   always_comb begin
      lv = '{default: '0};
      for (int k = 0; k < P; k++) begin
         lv[0][k] = (k < N) ? vals[k] : neutral(op);
      end
      for (int l = 0; l < L; l++) begin
         for (int k = 0; k < (P >> (l + 1)); k++) begin
            lv[l+1][k] = pick(op, lv[l][2*k], lv[l][2*k+1]);
         end
      end
   end

   assign result = lv[L][0];

endmodule

// File: rtl/core/gedf_front.sv
// -----------------------------------------------------------------------------
// gedf_front
// Accepts pixels, tracks input/output positions, classifies each item and
// reads the window column and the pass-through pixel from the line store.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gedf_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_RADIUS = 7
) (
   input  logic                         clock,
   input  logic                         reset,
   input  gedf_pkg::cfg_type            cfg,
   input  logic                         cfg_write,
   input  logic [gedf_pkg::PIX_W-1:0]   req_pixel_in,
   input  logic                         req_drain,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [gedf_pkg::QCNT_W-1:0]  q_count,
   output logic                         q_push,
   output gedf_pkg::ctl_type            q_ctl,
   output logic [gedf_pkg::PIX_W-1:0]   q_pass,
   output logic [2*MAX_RADIUS:0][gedf_pkg::PIX_W-1:0] q_column
);
   import gedf_pkg::*;

   localparam int SLOTS  = 2 * MAX_RADIUS;
   localparam int SIDE   = SLOTS + 1;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int XW     = ((COL_W > CNT_W) ? COL_W : CNT_W) + 1;

   logic [COL_W-1:0]  in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [CNT_W-1:0]  in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [SLOT_W-1:0] in_slot_ff, in_slot_in, out_slot_ff, out_slot_in;
   logic [IDX_W-1:0]  in_base_ff, in_base_in, out_base_ff, out_base_in, thr_ff;
   logic              recalc_ff;

   logic [COL_W-1:0]  in_col_e, out_col_e;
   logic [CNT_W-1:0]  in_row_e, out_row_e;
   logic [SLOT_W-1:0] in_slot_e, out_slot_e;
   logic [IDX_W-1:0]  in_base_e, out_base_e;
   logic              restart, take, accept, emit, interior, last;

   logic              f1_valid_ff;
   ctl_type           f1_ctl_ff;
   logic [PIX_W-1:0]  f1_pix_ff;
   logic [SLOT_W-1:0] f1_in_slot_ff, f1_out_slot_ff;

   logic [PIX_W-1:0]  rd_a_ff [SLOTS];
   logic [PIX_W-1:0]  rd_b_ff [SLOTS];

   assign req_full = recalc_ff ||
                     ((QCNT_W+1)'(q_count) + (QCNT_W+1)'(f1_valid_ff) >= (QCNT_W+1)'(QDEPTH));

   // A frame whose output row runs past the height starts over.
   assign restart    = out_row_ff >= cfg.height;
   assign in_col_e   = restart ? '0 : in_col_ff;
   assign out_col_e  = restart ? '0 : out_col_ff;
   assign in_row_e   = restart ? '0 : in_row_ff;
   assign out_row_e  = restart ? '0 : out_row_ff;
   assign in_slot_e  = restart ? '0 : in_slot_ff;
   assign out_slot_e = restart ? '0 : out_slot_ff;
   assign in_base_e  = restart ? '0 : in_base_ff;
   assign out_base_e = restart ? '0 : out_base_ff;

   assign take   = req_push && !req_full;
   assign accept = take && !req_drain && (in_row_e < cfg.height);

   always_comb begin
      logic [IDX_W-1:0] lhs, rhs;
      lhs = in_base_e + IDX_W'(in_col_e) + IDX_W'(1);
      rhs = out_base_e + IDX_W'(out_col_e) + thr_ff;
      if (accept) begin
         emit = lhs > rhs;
      end else begin
         emit = take && (in_row_e >= cfg.height);
      end
      interior = (out_row_e >= CNT_W'(cfg.radius)) &&
                 ((CNT_W+1)'(out_row_e) + (CNT_W+1)'(cfg.radius) < (CNT_W+1)'(cfg.height)) &&
                 (XW'(out_col_e) >= XW'(cfg.radius)) &&
                 (XW'(out_col_e) + XW'(cfg.radius) < XW'(cfg.width));
      last = (out_row_e == cfg.height - CNT_W'(1)) &&
             (XW'(out_col_e) == XW'(cfg.width) - XW'(1));
   end

   always_comb begin
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      in_slot_in  = in_slot_ff;
      in_base_in  = in_base_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      out_slot_in = out_slot_ff;
      out_base_in = out_base_ff;
      if (take) begin
         in_col_in   = in_col_e;
         in_row_in   = in_row_e;
         in_slot_in  = in_slot_e;
         in_base_in  = in_base_e;
         out_col_in  = out_col_e;
         out_row_in  = out_row_e;
         out_slot_in = out_slot_e;
         out_base_in = out_base_e;
         if (accept) begin
            if (XW'(in_col_e) + XW'(1) >= XW'(cfg.width)) begin
               in_col_in  = '0;
               in_row_in  = in_row_e + CNT_W'(1);
               in_slot_in = (in_slot_e == SLOT_W'(SLOTS - 1)) ? '0 : in_slot_e + SLOT_W'(1);
               in_base_in = in_base_e + IDX_W'(cfg.width);
            end else begin
               in_col_in = in_col_e + COL_W'(1);
            end
         end
         if (emit) begin
            if (XW'(out_col_e) + XW'(1) >= XW'(cfg.width)) begin
               out_col_in  = '0;
               out_row_in  = out_row_e + CNT_W'(1);
               out_slot_in = (out_slot_e == SLOT_W'(SLOTS - 1)) ? '0 : out_slot_e + SLOT_W'(1);
               out_base_in = out_base_e + IDX_W'(cfg.width);
            end else begin
               out_col_in = out_col_e + COL_W'(1);
            end
            // Last result of the frame: start over.
            if (out_row_in >= cfg.height) begin
               in_col_in   = '0;
               in_row_in   = '0;
               in_slot_in  = '0;
               in_base_in  = '0;
               out_col_in  = '0;
               out_row_in  = '0;
               out_slot_in = '0;
               out_base_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_slot_ff  <= '0;
         in_base_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_slot_ff <= '0;
         out_base_ff <= '0;
         thr_ff      <= '0;
         recalc_ff   <= 1'b1;
         f1_valid_ff <= 1'b0;
      end else begin
         recalc_ff   <= cfg_write;
         f1_valid_ff <= take && (accept || emit);
         if (recalc_ff) begin
            // Rebuild row offsets and the lag threshold for the current width.
            in_base_ff  <= IDX_W'(in_row_ff) * IDX_W'(cfg.width);
            out_base_ff <= IDX_W'(out_row_ff) * IDX_W'(cfg.width);
            thr_ff      <= IDX_W'(cfg.radius) * (IDX_W'(cfg.width) + IDX_W'(1));
         end else begin
            in_base_ff  <= in_base_in;
            out_base_ff <= out_base_in;
         end
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         in_slot_ff  <= in_slot_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         out_slot_ff <= out_slot_in;
      end
   end

   always_ff @(posedge clock) begin
      f1_ctl_ff      <= '{shift: accept, emit: emit, interior: interior, last: last};
      f1_pix_ff      <= req_pixel_in;
      f1_in_slot_ff  <= in_slot_e;
      f1_out_slot_ff <= out_slot_e;
   end

   // One line-store bank per row slot: column read, pass-through read, one write.
   for (genvar s = 0; s < SLOTS; s++) begin : g_bank
      logic [PIX_W-1:0] mem [MAX_WIDTH];
      always_ff @(posedge clock) begin
         if (accept && (in_slot_e == SLOT_W'(s))) begin
            mem[in_col_e] <= req_pixel_in;
         end
         rd_a_ff[s] <= mem[in_col_e];
         rd_b_ff[s] <= mem[out_col_e];
      end
   end

   always_comb begin
      int idx;
      q_column[0] = f1_pix_ff;
      for (int i = 1; i < SIDE; i++) begin
         idx = int'(f1_in_slot_ff) - i;
         if (idx < 0) begin
            idx = idx + SLOTS;
         end
         q_column[i] = rd_a_ff[SLOT_W'(idx)];
      end
   end

   assign q_pass = rd_b_ff[f1_out_slot_ff];
   assign q_push = f1_valid_ff;
   assign q_ctl  = f1_ctl_ff;

endmodule

// File: rtl/core/gedf_queue.sv
// -----------------------------------------------------------------------------
// gedf_queue
// Short register queue of classified items between the front and the back.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gedf_queue #(
   parameter int WIDTH = 132
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [WIDTH-1:0]            push_data,
   input  logic                        pop,
   output logic                        head_valid,
   output logic [WIDTH-1:0]            head_data,
   output logic [gedf_pkg::QCNT_W-1:0] count
);
   import gedf_pkg::*;

   logic [WIDTH-1:0]  data_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              do_pop;

   assign do_pop     = pop && (count_ff != '0);
   assign head_valid = count_ff != '0;
   assign head_data  = data_ff[rd_ptr_ff];
   assign count      = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_ff + QCNT_W'(push) - QCNT_W'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/gedf_back.sv
// -----------------------------------------------------------------------------
// gedf_back
// Column extremes, sliding window of column extremes, final select and the
// result register.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gedf_back #(
   parameter int MAX_RADIUS = 7
) (
   input  logic                        clock,
   input  logic                        reset,
   input  gedf_pkg::cfg_type           cfg,
   input  logic                        q_valid,
   input  gedf_pkg::ctl_type           q_ctl,
   input  logic [gedf_pkg::PIX_W-1:0]  q_pass,
   input  logic [2*MAX_RADIUS:0][gedf_pkg::PIX_W-1:0] q_column,
   output logic                        q_pop,
   output logic [gedf_pkg::PIX_W-1:0]  rsp_pixel_out,
   output logic                        rsp_frame_last,
   output logic                        rsp_empty,
   input  logic                        rsp_pop
);
   import gedf_pkg::*;

   localparam int SIDE = 2 * MAX_RADIUS + 1;

   logic [PIX_W-1:0] ext_ff [SIDE];
   logic [SIDE-1:0][PIX_W-1:0] col_vals, win_vals;
   logic [PIX_W-1:0] col_ext, win_ext;

   logic             s1_valid_ff;
   ctl_type          s1_ctl_ff;
   logic [PIX_W-1:0] s1_pass_ff;
   logic             out_valid_ff;
   logic [PIX_W-1:0] out_pix_ff;
   logic             out_last_ff;
   logic             s1_adv, s1_ready;

   // Mask rows and columns outside the current window to the neutral value.
   always_comb begin
      for (int k = 0; k < SIDE; k++) begin
         col_vals[k] = (k <= 2 * int'(cfg.radius)) ? q_column[k] : neutral(cfg.op);
         win_vals[k] = (k <= 2 * int'(cfg.radius)) ? ext_ff[SIDE-1-k] : neutral(cfg.op);
      end
   end

   gedf_tree #(.N(SIDE)) u_col_tree (
      .op     (cfg.op),
      .vals   (col_vals),
      .result (col_ext)
   );

   gedf_tree #(.N(SIDE)) u_win_tree (
      .op     (cfg.op),
      .vals   (win_vals),
      .result (win_ext)
   );

   assign s1_adv   = s1_valid_ff && (!s1_ctl_ff.emit || !out_valid_ff || rsp_pop);
   assign s1_ready = !s1_valid_ff || s1_adv;
   assign q_pop    = q_valid && s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int c = 0; c < SIDE; c++) begin
            ext_ff[c] <= '0;
         end
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= q_valid;
         end
         // Shift the window one column on each accepted pixel.
         if (q_pop && q_ctl.shift) begin
            for (int c = 0; c < SIDE - 1; c++) begin
               ext_ff[c] <= ext_ff[c+1];
            end
            ext_ff[SIDE-1] <= col_ext;
         end
         if (s1_adv && s1_ctl_ff.emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_ctl_ff  <= q_ctl;
         s1_pass_ff <= q_pass;
      end
      if (s1_adv && s1_ctl_ff.emit) begin
         out_pix_ff  <= s1_ctl_ff.interior ? win_ext : s1_pass_ff;
         out_last_ff <= s1_ctl_ff.last;
      end
   end

   assign rsp_pixel_out  = out_pix_ff;
   assign rsp_frame_last = out_last_ff;
   assign rsp_empty      = !out_valid_ff;

endmodule

// File: rtl/core/grayscale_erode_dilate_filter.sv
// -----------------------------------------------------------------------------
// grayscale_erode_dilate_filter
// Square-window grayscale erosion / dilation over a raster pixel stream.
// -----------------------------------------------------------------------------
// Usage:
//   Input queue (req_push / req_full) takes one pixel per clock in raster
//   order while req_full is low; req_drain items carry no pixel and flush
//   the tail of the frame. Result queue (rsp_empty / rsp_pop) gives the
//   filtered pixels in order, rsp_frame_last marking the frame's final pixel.
//   Result q of a frame appears with input item q + r*W + r; it reaches the
//   ports through the front register, the item queue, the back stage
//   register and the result register. Sustained rate is one item per cycle
//   while req_full is low: each line-store bank serves one column read, one
//   pass-through read and one write per cycle, and the min/max trees are
//   combinational, so nothing iterates. Pixels within r of an image edge
//   are copied from the line store. The APB port sets operation, radius,
//   width and height; after each write (and after reset) req_full stays high
//   for one cycle while row offsets and the lag threshold are rebuilt. The
//   line store needs no clearing pass. Reset empties the item queue and the
//   result register and zeroes the window. When the receiver stalls, the
//   result register holds, the item queue fills and req_full rises.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grayscale_erode_dilate_filter #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_RADIUS = 7
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [gedf_pkg::PIX_W-1:0]   req_pixel_in,
   input  logic                         req_drain,
   input  logic                         req_push,
   output logic                         req_full,
   output logic [gedf_pkg::PIX_W-1:0]   rsp_pixel_out,
   output logic                         rsp_frame_last,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [gedf_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [gedf_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [gedf_pkg::DATA_W-1:0]  csr_prdata,
   output logic                         csr_pready
);
   import gedf_pkg::*;

   localparam int SIDE = 2 * MAX_RADIUS + 1;
   localparam int QW   = CTL_W + PIX_W + SIDE * PIX_W;

   logic             op_ff;
   logic [RAD_W-1:0] radius_ff;
   logic [CNT_W-1:0] width_ff, height_ff;
   logic             cfg_write;
   logic [REG_IDX_W-1:0] reg_idx;
   cfg_type          cfg;

   logic              f_push, q_valid, q_pop;
   ctl_type           f_ctl, b_ctl;
   logic [PIX_W-1:0]  f_pass, b_pass;
   logic [SIDE-1:0][PIX_W-1:0] f_column, b_column;
   logic [QW-1:0]     q_head;
   logic [QCNT_W-1:0] q_count;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff     <= OP_ERODE;
         radius_ff <= RADIUS_RESET;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (cfg_write) begin
         case (reg_idx)
            REG_OPERATION: op_ff     <= csr_pwdata[0];
            REG_RADIUS:    radius_ff <= csr_pwdata[RAD_W-1:0];
            REG_WIDTH:     width_ff  <= csr_pwdata[CNT_W-1:0];
            REG_HEIGHT:    height_ff <= csr_pwdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_OPERATION: csr_prdata = DATA_W'(op_ff);
         REG_RADIUS:    csr_prdata = DATA_W'(radius_ff);
         REG_WIDTH:     csr_prdata = DATA_W'(width_ff);
         REG_HEIGHT:    csr_prdata = DATA_W'(height_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // Clamp the registers to the ranges the datapath supports.
   always_comb begin
      cfg.op     = op_ff;
      cfg.radius = (int'(radius_ff) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : radius_ff;
      if (width_ff == '0) begin
         cfg.width = CNT_W'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         cfg.width = CNT_W'(MAX_WIDTH);
      end else begin
         cfg.width = width_ff;
      end
      if (height_ff == '0) begin
         cfg.height = CNT_W'(1);
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         cfg.height = CNT_W'(MAX_HEIGHT);
      end else begin
         cfg.height = height_ff;
      end
   end

   gedf_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .cfg_write    (cfg_write),
      .req_pixel_in (req_pixel_in),
      .req_drain    (req_drain),
      .req_push     (req_push),
      .req_full     (req_full),
      .q_count      (q_count),
      .q_push       (f_push),
      .q_ctl        (f_ctl),
      .q_pass       (f_pass),
      .q_column     (f_column)
   );

   gedf_queue #(.WIDTH(QW)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (f_push),
      .push_data  ({f_ctl, f_pass, f_column}),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_head),
      .count      (q_count)
   );

   assign {b_ctl, b_pass, b_column} = q_head;

   gedf_back #(.MAX_RADIUS(MAX_RADIUS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .q_valid        (q_valid),
      .q_ctl          (b_ctl),
      .q_pass         (b_pass),
      .q_column       (b_column),
      .q_pop          (q_pop),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_frame_last (rsp_frame_last),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop)
   );

endmodule

// File: rtl/core/gedf_checker.sv
// -----------------------------------------------------------------------------
// gedf_checker
// Port-level checks for the erode/dilate filter, bound to the top level.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "grayscale_erode_dilate_filter_macros.svh"

module gedf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic [7:0] rsp_pixel_out,
   input logic       rsp_frame_last,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic       csr_psel,
   input logic       csr_penable,
   input logic       csr_pwrite
);

   // Reset leaves no result and blocks input while offsets are rebuilt.
   `GEDF_ASSERT_NEXT_ALWAYS(a_reset_state, clock, reset, rsp_empty && req_full, "bad reset state")

   // A register write blocks input for the rebuild cycle.
   `GEDF_ASSERT_NEXT(a_write_stall, clock, reset, csr_psel && csr_penable && csr_pwrite, req_full, "no stall after write")

   // A waiting result holds until taken.
   `GEDF_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_pixel_out) && $stable(rsp_frame_last), "result changed while stalled")

endmodule

bind grayscale_erode_dilate_filter gedf_checker u_gedf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_full       (req_full),
   .rsp_pixel_out  (rsp_pixel_out),
   .rsp_frame_last (rsp_frame_last),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .csr_psel       (csr_psel),
   .csr_penable    (csr_penable),
   .csr_pwrite     (csr_pwrite)
);

// File: tb/grayscale_erode_dilate_filter_tb.sv
// ----------------------------------------------------------------------------
// grayscale_erode_dilate_filter_tb
// Streams whole frames through the filter under several window settings and
// checks every filtered pixel and frame-end flag against an in-bench model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grayscale_erode_dilate_filter_tb;
   import gedf_pkg::*;

   localparam int LINE_W    = 1024;
   localparam int RAD_MAX   = 7;
   localparam int LINE_ROWS = 2 * RAD_MAX;
   localparam int SIDE      = 2 * RAD_MAX + 1;
   localparam int STALL_CAP = 5000;

   typedef struct {
      logic [PIX_W-1:0] pix;
      logic             drain;
   } pixel_item_type;

   typedef struct {
      logic [PIX_W-1:0] pix;
      logic             last;
   } pixel_result_type;

   logic                clock;
   logic                reset;
   logic [PIX_W-1:0]    req_pixel_in;
   logic                req_drain;
   logic                req_push;
   logic                req_full;
   logic [PIX_W-1:0]    rsp_pixel_out;
   logic                rsp_frame_last;
   logic                rsp_empty;
   logic                rsp_pop;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [ADDR_W-1:0]   csr_paddr;
   logic [DATA_W-1:0]   csr_pwdata;
   logic [DATA_W-1:0]   csr_prdata;
   logic                csr_pready;

   grayscale_erode_dilate_filter dut (.*);

   // filter state kept by the bench
   logic [PIX_W-1:0] line_mem [LINE_ROWS*LINE_W];
   logic [PIX_W-1:0] win [SIDE][SIDE];
   int unsigned      in_col, in_row, out_col, out_row;
   logic             cfg_op;
   logic [RAD_W-1:0] cfg_radius;
   logic [CNT_W-1:0] cfg_width, cfg_height;

   pixel_item_type   pending_pixels[$];
   pixel_result_type expected_pixels[$];

   int errors, items_sent, results_seen, frames_run, erode_frames, dilate_frames;
   int feed_wait, drain_wait, hold_left, idle_cycles;
   bit hold_done;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int eff_width();
      if (cfg_width < 1) return 1;
      if (cfg_width > LINE_W) return LINE_W;
      return cfg_width;
   endfunction

   function automatic int eff_height();
      if (cfg_height < 1) return 1;
      if (cfg_height > MAX_HEIGHT) return MAX_HEIGHT;
      return cfg_height;
   endfunction

   function automatic logic [PIX_W-1:0] window_extreme(input int r);
      int lo;
      logic [PIX_W-1:0] best;
      lo   = SIDE - 1 - 2 * r;
      best = win[SIDE-1][SIDE-1];
      for (int j = lo; j < SIDE; j++) begin
         for (int c = lo; c < SIDE; c++) begin
            if (cfg_op == OP_DILATE ? (win[j][c] > best) : (win[j][c] < best)) begin
               best = win[j][c];
            end
         end
      end
      return best;
   endfunction

   // Advance the filter model by one item and queue the pixel it releases.
   task automatic filter_step(input logic [PIX_W-1:0] pix, input logic drn);
      int w, h, r, slot, col;
      bit take, emit, interior;
      logic [PIX_W-1:0] pass;
      pixel_result_type res;
      w = eff_width();
      h = eff_height();
      r = cfg_radius;
      if (out_row >= h) begin
         in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      end
      take = !drn && in_row < h;
      pass = line_mem[(out_row % LINE_ROWS) * LINE_W + (out_col % LINE_W)];
      if (take) begin
         slot = in_row % LINE_ROWS;
         col  = in_col % LINE_W;
         for (int j = 0; j < SIDE; j++)
            for (int c = 0; c + 1 < SIDE; c++)
               win[j][c] = win[j][c+1];
         for (int i = 1; i <= LINE_ROWS; i++)
            win[SIDE-1-i][SIDE-1] = line_mem[((slot + LINE_ROWS - i) % LINE_ROWS) * LINE_W + col];
         win[SIDE-1][SIDE-1] = pix;
         emit = in_row * w + in_col + 1 > out_row * w + out_col + r * w + r;
      end else begin
         emit = in_row >= h;
      end
      interior = out_row >= r && out_row + r < h && out_col >= r && out_col + r < w;
      res.pix  = interior ? window_extreme(r) : pass;
      if (take) begin
         line_mem[(in_row % LINE_ROWS) * LINE_W + (in_col % LINE_W)] = pix;
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
         end
      end
      if (emit) begin
         res.last = (out_row == h - 1) && (out_col == w - 1);
         expected_pixels.push_back(res);
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
         if (out_row >= h) begin
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
         end
      end
   endtask

   task automatic report(input string what, input int got, input int want);
      errors++;
      $display("MISMATCH %s at result %0d: got %0d, want %0d", what, results_seen, got, want);
   endtask

   // Driver: hold the item while full, otherwise advance after a transfer.
   always @(posedge clock) begin
      pixel_item_type nxt;
      if (reset) begin
         req_push     <= 1'b0;
         req_pixel_in <= '0;
         req_drain    <= 1'b0;
         feed_wait    = 0;
      end else if (!(req_push && req_full)) begin
         if (req_push) begin
            filter_step(req_pixel_in, req_drain);
            items_sent++;
         end
         if (feed_wait > 0) begin
            feed_wait--;
            req_push <= 1'b0;
         end else if (pending_pixels.size() > 0) begin
            nxt = pending_pixels.pop_front();
            req_pixel_in <= nxt.pix;
            req_drain    <= nxt.drain;
            req_push     <= 1'b1;
            feed_wait    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // Receiver hold: one long stretch without pops once 150 results are in.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (results_seen >= 150 && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= 400;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Monitor: check each popped pixel, then draw the stall before the next.
   always @(posedge clock) begin
      pixel_result_type want;
      if (reset) begin
         rsp_pop    <= 1'b0;
         drain_wait = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_pixels.size() == 0) begin
               report("unexpected pixel", rsp_pixel_out, -1);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_pixel_out !== want.pix) report("pixel_out", rsp_pixel_out, want.pix);
               if (rsp_frame_last !== want.last)
                  report("frame_last", rsp_frame_last, want.last);
            end
            results_seen++;
            drain_wait = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
         end
         if (hold_left > 0) begin
            rsp_pop <= 1'b0;
         end else if (drain_wait > 0) begin
            drain_wait--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Watchdog on cycles without any pixel transfer.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_CAP) begin
         $display("timeout: no transfer for %0d cycles", STALL_CAP);
         $display("grayscale_erode_dilate_filter_tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_W'(idx) << 2;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_OPERATION: cfg_op     = value[0];
         REG_RADIUS:    cfg_radius = value[RAD_W-1:0];
         REG_WIDTH:     cfg_width  = value[CNT_W-1:0];
         default:       cfg_height = value[CNT_W-1:0];
      endcase
   endtask

   task automatic wait_idle();
      do begin
         @(posedge clock);
         #1;
      end while (pending_pixels.size() != 0 || expected_pixels.size() != 0 || req_push);
      repeat (12) @(posedge clock);
   endtask

   // Queue one frame: pixels of the given style, stray drains, then the flush.
   // style 0 random, 1 extremes only, 2 ramp
   task automatic run_frame(input logic op, input int r, input int w, input int h,
                            input int style);
      int ew, eh, count, flush;
      pixel_item_type it;
      wait_idle();
      csr_write(REG_OPERATION, op);
      csr_write(REG_RADIUS, r);
      csr_write(REG_WIDTH, w);
      csr_write(REG_HEIGHT, h);
      ew    = eff_width();
      eh    = eff_height();
      count = ew * eh;
      flush = count - ((count > r * ew + r) ? count - (r * ew + r) : 0);
      frames_run++;
      if (op == OP_DILATE) dilate_frames++; else erode_frames++;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 29) == 0) begin
            it.pix   = $urandom_range(0, 255);
            it.drain = 1'b1;
            pending_pixels.push_back(it);
         end
         case (style)
            1:       it.pix = $urandom_range(0, 1) ? 8'hff : 8'h00;
            2:       it.pix = PIX_W'(k * 37);
            default: it.pix = $urandom_range(0, 255);
         endcase
         it.drain = 1'b0;
         pending_pixels.push_back(it);
      end
      // a pixel past the frame end acts as a flush item
      for (int k = 0; k < flush; k++) begin
         it.pix   = $urandom_range(0, 255);
         it.drain = ($urandom_range(0, 4) != 0);
         pending_pixels.push_back(it);
      end
   endtask

   initial begin
      reset       = 1'b1;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      cfg_op      = OP_ERODE;
      cfg_radius  = RADIUS_RESET;
      cfg_width   = WIDTH_RESET;
      cfg_height  = HEIGHT_RESET;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      for (int j = 0; j < SIDE; j++)
         for (int c = 0; c < SIDE; c++)
            win[j][c] = '0;
      for (int i = 0; i < LINE_ROWS * LINE_W; i++) line_mem[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed frames
      run_frame(OP_ERODE, 0, 1, 1, 1);
      run_frame(OP_DILATE, 1, 3, 3, 1);
      run_frame(OP_ERODE, 1, 5, 4, 1);
      run_frame(OP_DILATE, 7, 15, 15, 2);
      run_frame(OP_ERODE, 3, 0, 0, 0);
      run_frame(OP_DILATE, 2, 6, 2, 0);

      // random frames, mostly small
      while (items_sent < 460) begin
         run_frame($urandom_range(0, 1), $urandom_range(0, 7),
                   $urandom_range(1, 16), $urandom_range(1, 12), $urandom_range(0, 2));
      end

      // widest window over a frame just larger than it
      run_frame(OP_ERODE, 7, 16, 16, 0);

      wait_idle();
      repeat (20) @(posedge clock);
      $display("covered %0d frames (%0d erosion, %0d dilation), %0d items in, %0d pixels out",
               frames_run, erode_frames, dilate_frames, items_sent, results_seen);
      if (errors == 0) begin
         $display("grayscale_erode_dilate_filter_tb: done, clean");
      end else begin
         $display("%0d mismatches", errors);
         $display("grayscale_erode_dilate_filter_tb: done, errors");
      end
      $finish;
   end

endmodule
